@@ rtl/core/tcce_pkg.sv @@
package tcce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int CS_W = COL_W + 1;
  localparam int ROW_W = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  localparam int COPY_LAST = COLUMNS * (ROWS - 1) - 1;
  localparam int FILL_BASE = COLUMNS * (ROWS - 1);
  localparam int TAB_MAX = (COLUMNS < 16) ? COLUMNS : 16;

  localparam logic [1:0] FUNC_PUT = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [0:0] CFG_TAB_WIDTH = 1'b0;
  localparam logic [0:0] CFG_BLANK_ATTR = 1'b1;

  localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;
  localparam logic [7:0] BLANK_ATTR_RESET = 8'd7;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] attr;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } res_t;

  typedef struct packed {
    logic [4:0] tab_width;
    logic [7:0] blank_attr;
  } cfg_t;

  function automatic logic [4:0] eff_tab(input logic [4:0] tw);
    logic [4:0] t;
    t = tw;
    if (tw == 5'd0) begin
      t = 5'd1;
    end else if (int'(tw) > TAB_MAX) begin
      t = 5'(TAB_MAX);
    end
    return t;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * COLUMNS + int'(c));
  endfunction

endpackage

@@ rtl/core/tcce_cell_ram.sv @@
module tcce_cell_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tcce_pkg::ADDR_W-1:0] waddr,
  input  logic [15:0]                wdata,
  input  logic [tcce_pkg::ADDR_W-1:0] raddr,
  output logic [15:0]                rdata
);
  import tcce_pkg::*;

  logic [15:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tcce_seq.sv @@
module tcce_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  tcce_pkg::req_t              req,
  output logic                        busy,
  input  tcce_pkg::cfg_t              cfg,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tcce_pkg::res_t              res,
  output logic                        ram_we,
  output logic [tcce_pkg::ADDR_W-1:0] ram_waddr,
  output logic [15:0]                 ram_wdata,
  output logic [tcce_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [15:0]                 ram_rdata
);
  import tcce_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PUT   = 4'd1;
  localparam logic [3:0] S_TAB   = 4'd2;
  localparam logic [3:0] S_NL    = 4'd3;
  localparam logic [3:0] S_BS    = 4'd4;
  localparam logic [3:0] S_BSRD  = 4'd5;
  localparam logic [3:0] S_BSCHK = 4'd6;
  localparam logic [3:0] S_BSWR  = 4'd7;
  localparam logic [3:0] S_MARK  = 4'd8;
  localparam logic [3:0] S_RD    = 4'd9;
  localparam logic [3:0] S_RDW   = 4'd10;
  localparam logic [3:0] S_CLR   = 4'd11;
  localparam logic [3:0] S_SCP   = 4'd12;
  localparam logic [3:0] S_SDRN  = 4'd13;
  localparam logic [3:0] S_SFILL = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]        state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [15:0]       fill, fill_next;
  logic              quiet, quiet_next;
  logic              mark_pend, mark_pend_next;
  logic              scr, scr_next;
  logic [7:0]        cc, cc_next;
  logic [7:0]        ca, ca_next;
  req_t              rq, rq_next;

  logic [4:0]        tab;
  logic [ADDR_W-1:0] here;
  logic [4:0]        adv_n;
  logic [CS_W-1:0]   adv_sum;
  logic              adv_wrap;
  logic [COL_W-1:0]  adv_col;
  logic [4:0]        back_n;
  logic              back_under;
  logic [COL_W-1:0]  back_col;
  logic [ROW_W-1:0]  back_row;
  logic              row_last;
  logic              do_down;
  logic              rd_in_range;

  assign tab = eff_tab(cfg.tab_width);
  assign here = cell_addr(cur_row, cur_col);
  assign row_last = (cur_row == ROW_W'(ROWS - 1));

  assign adv_n = (state == S_TAB) ? tab : 5'd1;
  assign adv_sum = {1'b0, cur_col} + CS_W'(adv_n);
  assign adv_wrap = (adv_sum >= CS_W'(COLUMNS));
  assign adv_col = adv_wrap ? COL_W'(adv_n - 5'd1) : COL_W'(adv_sum);

  assign back_n = (state == S_BSCHK) ? (tab - 5'd1) : 5'd1;
  assign back_under = ({1'b0, cur_col} < CS_W'(back_n));
  assign back_col = back_under ? COL_W'(CS_W'(COLUMNS) - CS_W'(back_n))
                               : COL_W'({1'b0, cur_col} - CS_W'(back_n));
  assign back_row = (back_under && cur_row != '0) ? (cur_row - 1'b1) : cur_row;

  assign rd_in_range = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLUMNS);

  assign busy = (state != S_IDLE);

  assign res.cursor_col = 7'(cur_col);
  assign res.cursor_row = 5'(cur_row);
  assign res.scrolled = scr;
  assign res.cell_char = cc;
  assign res.cell_attr = ca;

  always_comb begin
    state_next = state;
    idx_next = idx;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    fill_next = fill;
    quiet_next = quiet;
    mark_pend_next = mark_pend;
    scr_next = scr;
    cc_next = cc;
    ca_next = ca;
    rq_next = rq;
    do_down = 1'b0;
    ram_we = 1'b0;
    ram_waddr = here;
    ram_wdata = fill;
    ram_raddr = here;
    res_valid = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          rq_next = req;
          scr_next = 1'b0;
          cc_next = 8'd0;
          ca_next = 8'd0;
          mark_pend_next = 1'b0;
          unique case (req.func)
            FUNC_PUT: begin
              priority if (req.char_code == CH_TAB) begin
                state_next = S_TAB;
              end else if (req.char_code == CH_NL) begin
                state_next = S_NL;
              end else if (req.char_code == CH_BS) begin
                state_next = S_BS;
              end else begin
                state_next = S_PUT;
              end
            end
            FUNC_CLEAR: begin
              fill_next = {req.attr, CH_SPACE};
              idx_next = '0;
              quiet_next = 1'b0;
              state_next = S_CLR;
            end
            FUNC_READ: begin
              state_next = rd_in_range ? S_RD : S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_PUT, S_TAB: begin
        if (state == S_PUT) begin
          ram_we = 1'b1;
          ram_wdata = {rq.attr, rq.char_code};
        end
        cur_col_next = adv_col;
        mark_pend_next = (state == S_TAB);
        if (adv_wrap) begin
          do_down = 1'b1;
        end else begin
          state_next = (state == S_TAB) ? S_MARK : S_DONE;
        end
      end
      S_NL: begin
        cur_col_next = '0;
        do_down = 1'b1;
      end
      S_BS: begin
        cur_col_next = back_col;
        cur_row_next = back_row;
        state_next = S_BSRD;
      end
      S_BSRD: begin
        state_next = S_BSCHK;
      end
      S_BSCHK: begin
        if (ram_rdata[7:0] == CH_TAB) begin
          cur_col_next = back_col;
          cur_row_next = back_row;
        end
        state_next = S_BSWR;
      end
      S_BSWR: begin
        ram_we = 1'b1;
        ram_wdata = {cfg.blank_attr, CH_SPACE};
        state_next = S_DONE;
      end
      S_MARK: begin
        ram_we = 1'b1;
        ram_wdata = {cfg.blank_attr, CH_TAB};
        state_next = S_DONE;
      end
      S_RD: begin
        ram_raddr = cell_addr(ROW_W'(rq.read_row), COL_W'(rq.read_col));
        state_next = S_RDW;
      end
      S_RDW: begin
        cc_next = ram_rdata[7:0];
        ca_next = ram_rdata[15:8];
        state_next = S_DONE;
      end
      S_CLR: begin
        ram_we = 1'b1;
        ram_waddr = idx;
        if (idx == ADDR_W'(CELLS - 1)) begin
          idx_next = '0;
          cur_col_next = '0;
          cur_row_next = '0;
          state_next = quiet ? S_IDLE : S_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_SCP: begin
        ram_raddr = idx + ADDR_W'(COLUMNS);
        ram_we = (idx != '0);
        ram_waddr = idx - 1'b1;
        ram_wdata = ram_rdata;
        if (idx == ADDR_W'(COPY_LAST)) begin
          state_next = S_SDRN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_SDRN: begin
        ram_we = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        idx_next = '0;
        state_next = S_SFILL;
      end
      S_SFILL: begin
        ram_we = 1'b1;
        ram_waddr = ADDR_W'(FILL_BASE) + idx;
        ram_wdata = {cfg.blank_attr, CH_SPACE};
        if (idx == ADDR_W'(COLUMNS - 1)) begin
          idx_next = '0;
          state_next = mark_pend ? S_MARK : S_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_down) begin
      if (row_last) begin
        scr_next = 1'b1;
        idx_next = '0;
        state_next = S_SCP;
      end else begin
        cur_row_next = cur_row + 1'b1;
        state_next = mark_pend_next ? S_MARK : S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
      cur_col <= '0;
      cur_row <= '0;
      fill <= {BLANK_ATTR_RESET, CH_SPACE};
      quiet <= 1'b1;
      mark_pend <= 1'b0;
      scr <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      fill <= fill_next;
      quiet <= quiet_next;
      mark_pend <= mark_pend_next;
      scr <= scr_next;
    end
  end

  always_ff @(posedge clk) begin
    cc <= cc_next;
    ca <= ca_next;
    rq <= rq_next;
  end

endmodule

@@ rtl/core/text_console_character_engine_core.sv @@
// Channel   Direction  Handshake          Payload
// request   in         in_valid/in_stall  func, char_code, attr, read_row, read_col
// result    out        out_valid/out_stall cursor_col, cursor_row, scrolled,
//                                          cell_char, cell_attr
// config    in         cfg_we             cfg_index, cfg_data
//
// A read uses the one cell RAM read port, whose data is registered. A scroll copies
// each row up through the RAM read and write ports, then fills the bottom row;
// clear writes every cell in turn.
// Reset runs a clearing pass over every cell with in_stall high.
// in_stall is high while a request runs or its result waits on a held output.
module text_console_character_engine_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] char_code,
  input  logic [7:0] attr,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic       scrolled,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tcce_pkg::*;

  cfg_t              cfg;
  req_t              req;
  res_t              res;
  logic              busy;
  logic              res_valid;
  logic              res_ready;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  assign req.func = func;
  assign req.char_code = char_code;
  assign req.attr = attr;
  assign req.read_row = read_row;
  assign req.read_col = read_col;

  assign in_stall = busy;
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tab_width <= TAB_WIDTH_RESET;
      cfg.blank_attr <= BLANK_ATTR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAB_WIDTH:  cfg.tab_width <= cfg_data[4:0];
        CFG_BLANK_ATTR: cfg.blank_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      cursor_col <= res.cursor_col;
      cursor_row <= res.cursor_row;
      scrolled <= res.scrolled;
      cell_char <= res.cell_char;
      cell_attr <= res.cell_attr;
    end
  end

  tcce_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req       (req),
    .busy      (busy),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcce_cell_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ rtl/core/tcce_checker.sv @@
module tcce_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] cursor_col,
  input logic [4:0] cursor_row,
  input logic       scrolled,
  input logic [7:0] cell_char,
  input logic [7:0] cell_attr
);
  import tcce_pkg::*;

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in progress");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(cursor_col) < COLUMNS) && (int'(cursor_row) < ROWS))
    else $error("cursor out of screen");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> cursor_row == 5'(ROWS - 1))
    else $error("scroll without cursor on last row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cursor_col) && $stable(cell_char)
      && $stable(cell_attr))
    else $error("stalled result changed");

endmodule

bind text_console_character_engine_core tcce_checker u_tcce_checker (.*);
